// File: rtl/core/ibc_pkg.sv
// Shared types and constants of the remote-control bus frame checker.
// No dependencies; every other file of the block imports this package.
package ibc_pkg;

  localparam int FRAME_BYTES    = 32;
  localparam int CHANNELS       = 7;
  localparam int CH_FIRST_BYTE  = 2;
  localparam int CH_W           = 16;
  localparam int BYTE_W         = 8;
  localparam int CFG_W          = 16;
  localparam int CFG_ADDR_W     = 1;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int OUT_DATA_BITS  = CHANNELS * CH_W + 2;
  localparam int OUT_DATA_W     = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam logic [CH_W-1:0] SUM_INIT = 16'hFFFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_FAILSAFE_CODE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_THROTTLE_FLOOR = 1'd1;

  localparam logic [CFG_W-1:0] FAILSAFE_CODE_RST  = 16'd1500;
  localparam logic [CFG_W-1:0] THROTTLE_FLOOR_RST = 16'd1010;

  localparam int CH_LEFT_VERTICAL = 2;
  localparam int CH_SWITCH_D      = 6;

  typedef logic [CHANNELS-1:0][CH_W-1:0] chan_set_t;

  typedef struct packed {
    logic      ok;
    chan_set_t chans;
  } frame_t;

endpackage

// File: rtl/core/ibc_front.sv
// Front end: counts frame bytes, keeps the running checksum and stages channels.
// Depends on ibc_pkg; pushes one checked frame record per completed frame.
module ibc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [ibc_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       frame_start,
  output logic                       push,
  output ibc_pkg::frame_t            push_data
);
  import ibc_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] SUM_LO_POS = CNT_W'(FRAME_BYTES - 2);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, pos;
  logic [CH_W-1:0]   sum_r, sum_nxt, sum_cur;
  logic [BYTE_W-1:0] lo_r, lo_nxt;
  chan_set_t         stage_r, stage_nxt;

  always_comb begin
    pos       = frame_start ? '0 : cnt_r;
    sum_cur   = frame_start ? SUM_INIT : sum_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    stage_nxt = stage_r;
    push      = 1'b0;
    if (accept) begin
      if (pos < SUM_LO_POS) begin
        sum_nxt = sum_cur - {{(CH_W-BYTE_W){1'b0}}, rx_byte};
        cnt_nxt = pos + 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (pos == CNT_W'(CH_FIRST_BYTE + 2 * i)) begin
            stage_nxt[i][BYTE_W-1:0] = rx_byte;
          end
          if (pos == CNT_W'(CH_FIRST_BYTE + 2 * i + 1)) begin
            stage_nxt[i][CH_W-1:BYTE_W] = rx_byte;
          end
        end
      end else if (pos == SUM_LO_POS) begin
        sum_nxt = sum_cur;
        lo_nxt  = rx_byte;
        cnt_nxt = pos + 1'b1;
      end else begin
        push    = 1'b1;
        cnt_nxt = '0;
        sum_nxt = SUM_INIT;
      end
    end
    push_data.ok    = (sum_cur[BYTE_W-1:0] == lo_r) && (sum_cur[CH_W-1:BYTE_W] == rx_byte);
    push_data.chans = stage_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_r   <= SUM_INIT;
      lo_r    <= '0;
      stage_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      lo_r    <= lo_nxt;
      stage_r <= stage_nxt;
    end
  end

endmodule

// File: rtl/core/ibc_queue.sv
// Short register queue of checked frame records between front and back end.
// Depends on ibc_pkg for the record type.
module ibc_queue #(
  parameter int DEPTH = ibc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ibc_pkg::frame_t push_data,
  input  logic            pop,
  output ibc_pkg::frame_t pop_data,
  output logic            full,
  output logic            empty
);
  import ibc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not shrink on pop");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/ibc_back.sv
// Back end: holds good channels and config, forms and registers each result.
// Depends on ibc_pkg; drains the frame record queue one entry per result.
module ibc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ibc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ibc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           q_empty,
  input  ibc_pkg::frame_t                q_data,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ibc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser
);
  import ibc_pkg::*;

  logic [CFG_W-1:0] failsafe_r, failsafe_nxt, floor_r, floor_nxt;
  chan_set_t        held_r, held_nxt;
  logic             valid_r, valid_nxt;
  logic             ok_r, ok_nxt;
  logic             fs_r, fs_nxt, tl_r, tl_nxt;

  always_comb begin
    failsafe_nxt = failsafe_r;
    floor_nxt    = floor_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_FAILSAFE_CODE:  failsafe_nxt = cfg_wdata;
        CFG_THROTTLE_FLOOR: floor_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pop       = !q_empty && (!valid_r || out_tready);
    held_nxt  = held_r;
    ok_nxt    = ok_r;
    fs_nxt    = fs_r;
    tl_nxt    = tl_r;
    valid_nxt = valid_r && !out_tready;
    if (pop) begin
      if (q_data.ok) begin
        held_nxt = q_data.chans;
      end
      valid_nxt = 1'b1;
      ok_nxt    = q_data.ok;
      fs_nxt    = (held_nxt[CH_SWITCH_D] == failsafe_r);
      tl_nxt    = (held_nxt[CH_LEFT_VERTICAL] < floor_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failsafe_r <= FAILSAFE_CODE_RST;
      floor_r    <= THROTTLE_FLOOR_RST;
      held_r     <= '0;
      valid_r    <= 1'b0;
    end else begin
      failsafe_r <= failsafe_nxt;
      floor_r    <= floor_nxt;
      held_r     <= held_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    fs_r <= fs_nxt;
    tl_r <= tl_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_DATA_BITS){1'b0}}, tl_r, fs_r, held_r};

  a_ok_updates_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_data.ok) |=> (held_r == $past(q_data.chans)))
    else $error("good frame did not update held channels");

  a_bad_keeps_held: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_data.ok) |=> $stable(held_r))
    else $error("held channels changed without a good frame");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_tvalid && out_tuser == $past(q_data.ok)))
    else $error("result register not loaded on pop");

endmodule

// File: rtl/core/ibus_frame_checker.sv
// Remote-control bus frame checker: one byte per cycle in, one result per frame out.
// A result is queued when the last byte of its frame is accepted, then popped into a result register and presented.
// Input is taken at one byte per cycle while the queue is not full; the result queue decouples output stalls.
// Reset is synchronous, active low: byte count and checksum restart, held
// channels clear to zero and the config registers return to 1500 and 1010.
module ibus_frame_checker #(
  parameter int QUEUE_DEPTH = ibc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ibc_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                           in_tuser,   // [0] frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] right_horizontal, [31:16] right_vertical, [47:32] left_vertical,
  // [63:48] left_horizontal, [79:64] switch_a, [95:80] switch_c,
  // [111:96] switch_d, [112] fail_safe, [113] throttle_low, rest zero
  output logic [ibc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,  // [0] frame_ok
  input  logic                           cfg_wr_en,
  input  logic [ibc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ibc_pkg::CFG_W-1:0]      cfg_wdata
);
  import ibc_pkg::*;

  logic   accept, push, pop, q_full, q_empty;
  frame_t push_data, q_data;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  ibc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser),
    .push        (push),
    .push_data   (push_data)
  );

  ibc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ibc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
